// ===== rtl/sfbsh_pkg.sv =====
// Shared types, constants and mixing functions of the byte stream hash.
package sfbsh_pkg;

   localparam int LENGTH_BITS = 31;
   localparam int WORD_BITS   = 32;
   localparam int HELD_BITS   = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BYTE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      OP_SEED     = 2'd0,
      OP_MIX      = 2'd1,
      OP_MIX_FIN  = 2'd2,
      OP_TAIL_FIN = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [1:0]           count;
      logic [WORD_BITS-1:0] data;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [WORD_BITS-1:0] sext8(input logic [7:0] b);
      return {{(WORD_BITS-8){b[7]}}, b};
   endfunction

   function automatic logic [WORD_BITS-1:0] mix_first(input logic [WORD_BITS-1:0] acc,
                                                      input logic [WORD_BITS-1:0] grp);
      logic [WORD_BITS-1:0] h;
      logic [WORD_BITS-1:0] hi;
      h  = acc + {16'd0, grp[15:0]};
      hi = {16'd0, grp[31:16]};
      return (h << 16) ^ (hi << 11) ^ h;
   endfunction

   function automatic logic [WORD_BITS-1:0] tail_first(input logic [WORD_BITS-1:0] acc,
                                                       input logic [HELD_BITS-1:0] held,
                                                       input logic [1:0]           count);
      logic [WORD_BITS-1:0] h;
      h = acc;
      unique case (count)
         2'd3: begin
            h = acc + {16'd0, held[15:0]};
            h = h ^ (h << 16);
            h = h ^ (sext8(held[23:16]) << 18);
         end
         2'd2: begin
            h = acc + {16'd0, held[15:0]};
            h = h ^ (h << 11);
         end
         2'd1: begin
            h = acc + sext8(held[7:0]);
            h = h ^ (h << 10);
         end
         default: h = acc;
      endcase
      return h;
   endfunction

   function automatic logic [WORD_BITS-1:0] tail_second(input logic [WORD_BITS-1:0] acc,
                                                        input logic [1:0]           count);
      logic [WORD_BITS-1:0] h;
      h = acc;
      unique case (count)
         2'd3:    h = acc + (acc >> 11);
         2'd2:    h = acc + (acc >> 17);
         2'd1:    h = acc + (acc >> 1);
         default: h = acc;
      endcase
      return h;
   endfunction

endpackage

// ===== rtl/sfbsh_front.sv =====
// Front end: accepts requests, tracks message position and groups bytes into operations.
module sfbsh_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [7:0]                      req_data_byte,
   input  logic [sfbsh_pkg::LENGTH_BITS-1:0] req_length,
   input  sfbsh_pkg::queue_status_type     q_stat,
   output logic                            push,
   output sfbsh_pkg::op_type               push_op
);
   import sfbsh_pkg::*;

   logic                   active_ff, active_in;
   logic [1:0]             gpos_ff, gpos_in;
   logic [HELD_BITS-1:0]   pending_ff, pending_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic                   accept;
   logic                   last;
   logic [HELD_BITS-1:0]   new_pending;

   assign req_stall = q_stat.full;
   assign accept    = req_valid & ~q_stat.full;
   assign last      = (remaining_ff == LENGTH_BITS'(1));
   assign new_pending = pending_ff | (HELD_BITS'(req_data_byte) << {gpos_ff, 3'b000});

   always_comb begin
      active_in    = active_ff;
      gpos_in      = gpos_ff;
      pending_in   = pending_ff;
      remaining_in = remaining_ff;
      push         = 1'b0;
      push_op      = '{kind: OP_SEED, count: 2'd0, data: '0};
      if (accept) begin
         if (command_type'(req_command) == CMD_START) begin
            push         = 1'b1;
            push_op.data = WORD_BITS'(req_length);
            pending_in   = '0;
            gpos_in      = 2'd0;
            remaining_in = req_length;
            active_in    = (req_length != '0);
         end else if (active_ff) begin
            remaining_in = remaining_ff - LENGTH_BITS'(1);
            if (gpos_ff == 2'd3) begin
               push         = 1'b1;
               push_op.kind = last ? OP_MIX_FIN : OP_MIX;
               push_op.data = {req_data_byte, pending_ff};
               pending_in   = '0;
               gpos_in      = 2'd0;
               active_in    = ~last;
            end else if (last) begin
               push          = 1'b1;
               push_op.kind  = OP_TAIL_FIN;
               push_op.count = gpos_ff + 2'd1;
               push_op.data  = WORD_BITS'(new_pending);
               pending_in    = '0;
               gpos_in       = 2'd0;
               active_in     = 1'b0;
            end else begin
               pending_in = new_pending;
               gpos_in    = gpos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         gpos_ff      <= 2'd0;
         pending_ff   <= '0;
         remaining_ff <= '0;
      end else begin
         active_ff    <= active_in;
         gpos_ff      <= gpos_in;
         pending_ff   <= pending_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ===== rtl/sfbsh_queue.sv =====
// Short operation queue between the front end and the mixing back end.
module sfbsh_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sfbsh_pkg::op_type           push_op,
   input  logic                        pop,
   output sfbsh_pkg::op_type           head_op,
   output sfbsh_pkg::queue_status_type q_stat
);
   import sfbsh_pkg::*;

   op_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign head_op      = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/sfbsh_back.sv =====
// Back end: runs group mixing, tail folding and avalanche, and holds the response register.
module sfbsh_back (
   input  logic                                clock,
   input  logic                                reset,
   input  sfbsh_pkg::queue_status_type         q_stat,
   input  sfbsh_pkg::op_type                   head_op,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sfbsh_pkg::WORD_BITS-1:0]     rsp_hash_value
);
   import sfbsh_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MIX2  = 6'b000010,
      ST_TAIL2 = 6'b000100,
      ST_AVA1  = 6'b001000,
      ST_AVA2  = 6'b010000,
      ST_AVA3  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 fin_ff, fin_in;
   logic [1:0]           count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_hash_ff, rsp_hash_in;
   logic                 out_free;
   logic [WORD_BITS-1:0] x3, x4, x25;

   assign out_free       = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign x3             = acc_ff ^ (acc_ff << 3);
   assign x4             = acc_ff ^ (acc_ff << 4);
   assign x25            = acc_ff ^ (acc_ff << 25);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               unique case (head_op.kind)
                  OP_SEED: begin
                     if (head_op.data == '0) begin
                        if (out_free) begin
                           pop          = 1'b1;
                           acc_in       = '0;
                           rsp_valid_in = 1'b1;
                           rsp_hash_in  = '0;
                        end
                     end else begin
                        pop    = 1'b1;
                        acc_in = head_op.data;
                     end
                  end
                  OP_MIX, OP_MIX_FIN: begin
                     pop      = 1'b1;
                     acc_in   = mix_first(acc_ff, head_op.data);
                     fin_in   = (head_op.kind == OP_MIX_FIN);
                     state_in = ST_MIX2;
                  end
                  OP_TAIL_FIN: begin
                     pop      = 1'b1;
                     acc_in   = tail_first(acc_ff, head_op.data[HELD_BITS-1:0], head_op.count);
                     count_in = head_op.count;
                     state_in = ST_TAIL2;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MIX2: begin
            acc_in   = acc_ff + (acc_ff >> 11);
            state_in = fin_ff ? ST_AVA1 : ST_IDLE;
         end
         ST_TAIL2: begin
            acc_in   = tail_second(acc_ff, count_ff);
            state_in = ST_AVA1;
         end
         ST_AVA1: begin
            acc_in   = x3 + (x3 >> 5);
            state_in = ST_AVA2;
         end
         ST_AVA2: begin
            acc_in   = x4 + (x4 >> 17);
            state_in = ST_AVA3;
         end
         ST_AVA3: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = x25 + (x25 >> 6);
               acc_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_ff       <= 1'b0;
         count_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

// ===== rtl/superfast_byte_stream_hash.sv =====
// Top level of the byte stream hash: front end, operation queue and mixing back end.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_command, req_data_byte, req_length
//   rsp      out        rsp_valid/rsp_stall   rsp_hash_value
//
// Data bytes are taken at one per cycle; req_stall rises when the queue is full. A
// four-byte group is mixed in ST_IDLE and ST_MIX2, a tail folded in ST_IDLE and ST_TAIL2,
// and a message end avalanched in ST_AVA1 to ST_AVA3, so back-to-back short messages run
// at the mixer's pace, buffered by a 4-entry queue. An empty start answers 0. Synchronous
// reset clears control state only; a stalled response holds in its output register.
module superfast_byte_stream_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [7:0]                        req_data_byte,
   input  logic [sfbsh_pkg::LENGTH_BITS-1:0] req_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sfbsh_pkg::WORD_BITS-1:0]   rsp_hash_value
);
   import sfbsh_pkg::*;

   queue_status_type q_stat;
   op_type           push_op;
   op_type           head_op;
   logic             q_push;
   logic             q_pop;

   sfbsh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .req_length    (req_length),
      .q_stat        (q_stat),
      .push          (q_push),
      .push_op       (push_op)
   );

   sfbsh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .head_op (head_op),
      .q_stat  (q_stat)
   );

   sfbsh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .head_op        (head_op),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_stat.full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the byte stream hash: directed, random and backpressure traffic.
`timescale 1ns / 100ps

module testbench;

   import sfbsh_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_command = CMD_BYTE;
   logic [7:0]             req_data_byte = 8'd0;
   logic [LENGTH_BITS-1:0] req_length = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WORD_BITS-1:0]   rsp_hash_value;

   // predicted hash state
   logic [31:0]            acc_hash;
   logic [23:0]            held_bytes;
   logic [1:0]             held_count;
   logic [LENGTH_BITS-1:0] bytes_left;
   logic                   in_message;

   logic [31:0]            pending_hashes[$];

   bit idle_on = 1'b0;
   int errors = 0;
   int requests_sent = 0;
   int noise_sent = 0;
   int hashes_checked = 0;
   int input_stall_cycles = 0;
   int hold_requests = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int burst_left = 0;

   superfast_byte_stream_hash DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_data_byte  (req_data_byte),
      .req_length     (req_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic logic [31:0] widen_signed_byte(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

   function automatic logic [31:0] finish_hash(input logic [31:0] acc, input logic [23:0] held,
                                               input logic [1:0] count);
      logic [31:0] h;
      h = acc;
      case (count)
         2'd3: begin
            h = h + {16'd0, held[15:0]};
            h = h ^ (h << 16);
            h = h ^ (widen_signed_byte(held[23:16]) << 18);
            h = h + (h >> 11);
         end
         2'd2: begin
            h = h + {16'd0, held[15:0]};
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         2'd1: begin
            h = h + widen_signed_byte(held[7:0]);
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: h = acc;
      endcase
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

   function automatic bit advance_hash(input logic cmd, input logic [7:0] data,
                                       input logic [LENGTH_BITS-1:0] len,
                                       output logic [31:0] hash_out);
      logic [15:0] hi;
      logic [31:0] h;
      logic [31:0] mixed;
      hash_out = '0;
      if (cmd == CMD_START) begin
         held_bytes = '0;
         held_count = '0;
         if (len == '0) begin
            acc_hash   = '0;
            bytes_left = '0;
            in_message = 1'b0;
            return 1'b1;
         end
         acc_hash   = {{(32-LENGTH_BITS){1'b0}}, len};
         bytes_left = len;
         in_message = 1'b1;
         return 1'b0;
      end
      if (!in_message)
         return 1'b0;
      if (held_count == 2'd3) begin
         hi = {data, held_bytes[23:16]};
         h = acc_hash + {16'd0, held_bytes[15:0]};
         mixed = ({16'd0, hi} << 11) ^ h;
         h = (h << 16) ^ mixed;
         acc_hash = h + (h >> 11);
         held_bytes = '0;
         held_count = '0;
      end else begin
         held_bytes = held_bytes | ({16'd0, data} << (8 * held_count));
         held_count = held_count + 2'd1;
      end
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0) begin
         hash_out   = finish_hash(acc_hash, held_bytes, held_count);
         acc_hash   = '0;
         held_bytes = '0;
         held_count = '0;
         in_message = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // check results, then predict from the accepted request
   always @(posedge clock) begin
      logic [31:0] predicted;
      logic [31:0] oldest;
      if (reset) begin
         acc_hash   = '0;
         held_bytes = '0;
         held_count = '0;
         bytes_left = '0;
         in_message = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hashes.size() == 0) begin
               $display("%0t: unexpected hash, expected none, actual %h", $time, rsp_hash_value);
               errors++;
            end else begin
               oldest = pending_hashes.pop_front();
               if (rsp_hash_value !== oldest) begin
                  $display("%0t: hash mismatch, expected %h, actual %h",
                           $time, oldest, rsp_hash_value);
                  errors++;
               end
               hashes_checked++;
            end
         end
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (req_valid && !req_stall) begin
            if (advance_hash(req_command, req_data_byte, req_length, predicted))
               pending_hashes.push_back(predicted);
         end
      end
   end

   // receiver: long hold on request, else short random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_requests != hold_taken) begin
         hold_taken = hold_requests;
         hold_left  = 150;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         burst_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(input logic cmd, input logic [7:0] data,
                               input logic [LENGTH_BITS-1:0] len);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         req_data_byte = 8'($urandom_range(0, 255));
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_command   = cmd;
      req_data_byte = data;
      req_length    = len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic send_message(input int len);
      send_request(CMD_START, 8'd0, len[LENGTH_BITS-1:0]);
      repeat (len) send_request(CMD_BYTE, 8'($urandom_range(0, 255)), '0);
   endtask

   task automatic test_empty_and_idle;
      send_request(CMD_START, 8'hFF, '0);
      send_request(CMD_BYTE, 8'h00, '0);
      send_request(CMD_BYTE, 8'hFF, '1);
      send_request(CMD_START, 8'h00, '0);
      noise_sent += 2;
   endtask

   task automatic test_tails;
      send_request(CMD_START, 8'd0, 31'd1);
      send_request(CMD_BYTE, 8'h80, '0);
      send_request(CMD_START, 8'd0, 31'd2);
      send_request(CMD_BYTE, 8'hFF, '0);
      send_request(CMD_BYTE, 8'h7F, '0);
      send_request(CMD_START, 8'd0, 31'd3);
      send_request(CMD_BYTE, 8'h12, '0);
      send_request(CMD_BYTE, 8'h34, '0);
      send_request(CMD_BYTE, 8'h9A, '0);
      send_request(CMD_START, 8'd0, 31'd5);
      repeat (5) send_request(CMD_BYTE, 8'hFF, '0);
   endtask

   task automatic test_restart;
      send_request(CMD_START, 8'd0, '1);
      send_request(CMD_BYTE, 8'hA5, '0);
      send_request(CMD_BYTE, 8'h5A, '0);
      send_request(CMD_START, 8'd0, 31'd1);
      send_request(CMD_BYTE, 8'h01, '0);
   endtask

   task automatic test_random_traffic(input int target);
      int base;
      int noise_base;
      int kind;
      int len;
      base = requests_sent;
      noise_base = noise_sent;
      idle_on = 1'b1;
      while ((requests_sent - base) - (noise_sent - noise_base) < target) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            send_message($urandom_range(1, 8));
            len = $urandom_range(1, 3);
            repeat (len)
               send_request(CMD_BYTE, 8'($urandom_range(0, 255)), LENGTH_BITS'($urandom));
            noise_sent += len;
         end else if (kind == 1) begin
            send_request(CMD_START, 8'($urandom_range(0, 255)), '0);
         end else if (kind == 2) begin
            send_request(CMD_START, 8'd0, LENGTH_BITS'($urandom));
            repeat ($urandom_range(0, 5))
               send_request(CMD_BYTE, 8'($urandom_range(0, 255)), '0);
         end else if (kind == 3) begin
            send_message($urandom_range(16, 48));
         end else begin
            send_message($urandom_range(1, 12));
         end
      end
   endtask

   task automatic test_backpressure;
      idle_on = 1'b0;
      hold_requests++;
      repeat (30) send_message($urandom_range(1, 2));
   endtask

   task automatic test_steady_stream(input int target);
      int base;
      base = requests_sent;
      idle_on = 1'b0;
      while (requests_sent - base < target)
         send_message($urandom_range(1, 10));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_idle();
      test_tails();
      test_restart();
      test_random_traffic(650);
      test_backpressure();
      test_steady_stream(150);

      req_valid = 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("summary: %0d requests (%0d ignored bytes), %0d hashes checked",
               requests_sent, noise_sent, hashes_checked);
      $display("summary: empty, tail, restart, random and backpressure traffic; %0d stall cycles",
               input_stall_cycles);
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sfbsh_pkg.sv
rtl/sfbsh_front.sv
rtl/sfbsh_queue.sv
rtl/sfbsh_back.sv
rtl/superfast_byte_stream_hash.sv
sim/testbench.sv
